@@ hdl/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, codes and defaults of the signal light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  // Upper limits of the configurable sizes, and the fixed port widths.
  localparam int SIG_SLOTS = 4;
  localparam int MAX_PINS  = 16;

  localparam int NUM_SIGNALS_DEF = 4;
  localparam int NUM_PINS_DEF    = 16;

  localparam int ID_W   = 11;
  localparam int TYPE_W = 2;
  localparam int DATA_W = 64;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASKS = 2'd2;

  // Event kinds.
  localparam logic REQ_MSG   = 1'b0;
  localparam logic REQ_TIMER = 1'b1;

  // Signal types; the remaining codes behave as plain.
  localparam logic [TYPE_W-1:0] TYPE_PLAIN = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_BLINK = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_BRAKE = 2'd2;

  typedef logic [ID_W-1:0]   sig_id_t;
  typedef logic [TYPE_W-1:0] sig_type_t;

endpackage

`default_nettype wire

@@ hdl/slc_if.sv @@
// ----------------------------------------------------------------------------
// slc_if
// Valid/ready channels of the signal light controller: events in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [slc_pkg::ID_W-1:0]    msg_id;
  logic [slc_pkg::DATA_W-1:0]  msg_data;

  modport source (output valid, output req_type, output msg_id, output msg_data,
                  input ready);
  modport sink   (input valid, input req_type, input msg_id, input msg_data,
                  output ready);
endinterface

interface slc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [slc_pkg::MAX_PINS-1:0]      pin_levels;
  logic [slc_pkg::SIG_SLOTS-1:0]     signals_on;
  logic                              phase_now;

  modport source (output valid, output pin_levels, output signals_on,
                  output phase_now, input ready);
  modport sink   (input valid, input pin_levels, input signals_on,
                  input phase_now, output ready);
endinterface

`default_nettype wire

@@ hdl/signal_light_controller_core.sv @@
// ----------------------------------------------------------------------------
// signal_light_controller_core
// Drives light pins from message and blink timer events.
// ----------------------------------------------------------------------------
// An accepted event passes the input register, then the result register,
// before its result shows; only a stalled result side holds it back.
// Throughput: one event per cycle unless the result side stalls; the state
// update is one pass of compare and mask logic between the two registers.
// Reset: synchronous, active low; configuration, on bits, blink phase and
// pins clear to zero, and both pipeline stages empty.
`default_nettype none

module signal_light_controller_core #(
  parameter int NUM_SIGNALS = slc_pkg::NUM_SIGNALS_DEF,
  parameter int NUM_PINS    = slc_pkg::NUM_PINS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  slc_req_if.sink                                in_ch,
  slc_rsp_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [slc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PinW = slc_pkg::MAX_PINS;
  localparam int SigW = slc_pkg::SIG_SLOTS;

  // Configuration, split per signal.
  slc_pkg::sig_id_t    ids_r   [NUM_SIGNALS];
  slc_pkg::sig_type_t  types_r [NUM_SIGNALS];
  logic [NUM_PINS-1:0] masks_r [NUM_SIGNALS];

  // Controller state.
  logic [NUM_SIGNALS-1:0] on_r;
  logic                   phase_r;
  logic [NUM_PINS-1:0]    pins_r;

  // Input register.
  logic                     s1_valid_r;
  logic                     s1_type_r;
  slc_pkg::sig_id_t         s1_id_r;
  logic                     s1_nz_r;

  // Result register.
  logic                     out_valid_r;
  logic [PinW-1:0]          out_pins_r;
  logic [SigW-1:0]          out_on_r;
  logic                     out_phase_r;

  logic advance;
  logic in_ready;

  logic [NUM_SIGNALS-1:0] on_nxt;
  logic                   phase_nxt;
  logic [NUM_PINS-1:0]    pins_nxt;
  logic                   refresh;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_levels = out_pins_r;
  assign out_ch.signals_on = out_on_r;
  assign out_ch.phase_now  = out_phase_r;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SIGNALS; k++) begin
        ids_r[k]   <= '0;
        types_r[k] <= '0;
        masks_r[k] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_SIGNALS; k++) begin
        if (cfg_index == slc_pkg::CFG_IDX_IDS) begin
          ids_r[k] <= cfg_data[k*slc_pkg::ID_W +: slc_pkg::ID_W];
        end
        if (cfg_index == slc_pkg::CFG_IDX_TYPES) begin
          types_r[k] <= cfg_data[k*slc_pkg::TYPE_W +: slc_pkg::TYPE_W];
        end
        if (cfg_index == slc_pkg::CFG_IDX_MASKS) begin
          masks_r[k] <= cfg_data[k*PinW +: NUM_PINS];
        end
      end
    end
  end

  // Event handling. Signals are walked in index order so that later writes
  // win on shared pins; brakes are refreshed after a blinker turns off.
  always_comb begin
    on_nxt    = on_r;
    phase_nxt = phase_r;
    pins_nxt  = pins_r;
    refresh   = 1'b0;
    if (s1_type_r == slc_pkg::REQ_TIMER) begin
      phase_nxt = ~phase_r;
      for (int k = 0; k < NUM_SIGNALS; k++) begin
        if (types_r[k] == slc_pkg::TYPE_BLINK && on_r[k]) begin
          pins_nxt = phase_nxt ? (pins_nxt | masks_r[k]) : (pins_nxt & ~masks_r[k]);
        end
      end
    end else if (s1_id_r != '0) begin
      for (int k = 0; k < NUM_SIGNALS; k++) begin
        if (ids_r[k] == s1_id_r) begin
          pins_nxt  = s1_nz_r ? (pins_nxt | masks_r[k]) : (pins_nxt & ~masks_r[k]);
          on_nxt[k] = s1_nz_r;
          if (!s1_nz_r && types_r[k] == slc_pkg::TYPE_BLINK) begin
            refresh = 1'b1;
          end
        end
      end
      if (refresh) begin
        for (int k = 0; k < NUM_SIGNALS; k++) begin
          if (types_r[k] == slc_pkg::TYPE_BRAKE && on_nxt[k]) begin
            pins_nxt = pins_nxt | masks_r[k];
          end
        end
      end
    end
  end

  // Pipeline control and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      on_r        <= '0;
      phase_r     <= 1'b0;
      pins_r      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          on_r    <= on_nxt;
          phase_r <= phase_nxt;
          pins_r  <= pins_nxt;
        end
      end
    end
  end

  // Payload registers. Only the zero test of the data is kept.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_type_r <= in_ch.req_type;
      s1_id_r   <= in_ch.msg_id;
      s1_nz_r   <= |in_ch.msg_data;
    end
    if (advance && s1_valid_r) begin
      out_pins_r  <= PinW'(pins_nxt);
      out_on_r    <= SigW'(on_nxt);
      out_phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/slc_checker.sv @@
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the signal light controller, bound to signal_light_controller_core.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_checker #(
  parameter int NUM_SIGNALS = slc_pkg::NUM_SIGNALS_DEF,
  parameter int NUM_PINS    = slc_pkg::NUM_PINS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [slc_pkg::MAX_PINS-1:0]     pin_levels,
  input wire logic [slc_pkg::SIG_SLOTS-1:0]    signals_on,
  input wire logic                             phase_now
);

  // An empty result side never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // Reset leaves no result pending.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Pins and signals beyond the configured counts read zero while a result is valid.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((pin_levels >> NUM_PINS) == '0 &&
                   (signals_on >> NUM_SIGNALS) == '0))
    else $error("unused pin or signal bit set");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pin_levels) &&
                               $stable(signals_on) && $stable(phase_now))
    else $error("stalled result changed");

endmodule

bind signal_light_controller_core slc_checker #(
  .NUM_SIGNALS (NUM_SIGNALS),
  .NUM_PINS    (NUM_PINS)
) u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pin_levels (out_ch.pin_levels),
  .signals_on (out_ch.signals_on),
  .phase_now  (out_ch.phase_now)
);

`default_nettype wire
